### src/srox_pkg.sv
// ----------------------------------------------------------------------------
// srox_pkg
// Types and constants shared by the shift register output expander modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srox_pkg;

    localparam int MAX_CHIPS_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int BIT_IDX_W     = 3;
    localparam int CNT_W         = 6;   // width of the chip count register
    localparam int SLOT_W        = 6;   // a slot is always below the chip count
    localparam int REQ_W         = 2;
    localparam int PIN_W         = 9;

    localparam logic [REQ_W-1:0] REQ_PIN_SET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHIP_WR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PIN_RD  = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_ARG = 1'b1;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

### src/srox_image_mem.sv
// ----------------------------------------------------------------------------
// srox_image_mem
// Chip image store: one byte per chip, registered read, write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module srox_image_mem #(
    parameter int MAX_CHIPS = srox_pkg::MAX_CHIPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire srox_pkg::mem_req_t        req,
    output logic [srox_pkg::BYTE_W-1:0]    rd_data
);

    localparam int AW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    logic [srox_pkg::BYTE_W-1:0] image_ram [MAX_CHIPS];
    logic [MAX_CHIPS-1:0]        valid_reg;
    logic [srox_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        bypass;

    assign bypass  = req.wr_en && (req.wr_addr == req.rd_addr);
    assign rd_data = rd_data_reg;

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            image_ram[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            if (bypass)
            begin
                rd_data_reg <= req.wr_data;
            end
            else if (valid_reg[req.rd_addr[AW-1:0]])
            begin
                rd_data_reg <= image_ram[req.rd_addr[AW-1:0]];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en && bypass |=> rd_data == $past(req.wr_data))
        else $error("read of an entry written in the same cycle missed the new byte");

endmodule

`default_nettype wire

### src/srox_seq.sv
// ----------------------------------------------------------------------------
// srox_seq
// Request sequencer: decodes a request, reads, modifies and writes back the
// image and streams the image out through the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srox_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [srox_pkg::CNT_W-1:0]      n_chips,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [srox_pkg::REQ_W-1:0]      req_type,
    input  wire logic [srox_pkg::PIN_W-1:0]      pin_number,
    input  wire logic                            pin_level,
    input  wire logic [srox_pkg::BYTE_W-1:0]     chip_number,
    input  wire logic [srox_pkg::BYTE_W-1:0]     chip_byte,
    output srox_pkg::mem_req_t                   mem_req,
    input  wire logic [srox_pkg::BYTE_W-1:0]     rd_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 status,
    output logic                                 read_level,
    output logic                                 frame_valid,
    output logic [srox_pkg::BYTE_W-1:0]          frame_byte,
    output logic                                 last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [srox_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [srox_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [srox_pkg::BIT_IDX_W-1:0]    bit_reg, bit_next;
    logic                              level_reg, level_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              status_reg, status_next;
    logic                              read_level_reg, read_level_next;
    logic                              frame_valid_reg, frame_valid_next;
    logic [srox_pkg::BYTE_W-1:0]       frame_byte_reg, frame_byte_next;
    logic                              last_reg, last_next;

    logic                              out_free;
    logic                              out_load;
    logic [srox_pkg::SLOT_W-1:0]       pin_chip;
    logic                              pin_ok;
    logic                              chip_ok;
    logic [srox_pkg::SLOT_W-1:0]       pin_slot;
    logic [srox_pkg::SLOT_W-1:0]       chip_slot;
    logic [srox_pkg::BYTE_W-1:0]       bit_mask;
    logic                              emit_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // Pin p sits in slot n-1-p/8, which is the same as (8n-1-p)/8.
    assign pin_chip  = pin_number[srox_pkg::PIN_W-1:srox_pkg::BIT_IDX_W];
    assign pin_ok    = pin_chip < n_chips;
    assign chip_ok   = {2'b00, n_chips} > chip_number;
    assign pin_slot  = n_chips - srox_pkg::SLOT_W'(1) - pin_chip;
    assign chip_slot = n_chips - srox_pkg::SLOT_W'(1) - chip_number[srox_pkg::SLOT_W-1:0];
    assign bit_mask  = srox_pkg::BYTE_W'(1) << bit_reg;
    assign emit_last = (idx_reg + srox_pkg::SLOT_W'(1)) == n_chips;

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        idx_next         = idx_reg;
        bit_next         = bit_reg;
        level_next       = level_reg;
        mem_req          = '0;
        out_load         = 1'b0;
        status_next      = srox_pkg::STATUS_OK;
        read_level_next  = 1'b0;
        frame_valid_next = 1'b0;
        frame_byte_next  = '0;
        last_next        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    slot_next  = pin_slot;
                    bit_next   = pin_number[srox_pkg::BIT_IDX_W-1:0];
                    level_next = pin_level;
                    case (req_type)
                        srox_pkg::REQ_PIN_SET,
                        srox_pkg::REQ_PIN_RD:
                        begin
                            if (pin_ok)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pin_slot;
                                state_next = (req_type == srox_pkg::REQ_PIN_RD) ?
                                             ST_RD : ST_MOD;
                            end
                            else
                            begin
                                state_next = ST_ERR;
                            end
                        end
                        srox_pkg::REQ_CHIP_WR:
                        begin
                            if (chip_ok)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = chip_slot;
                                mem_req.wr_data = chip_byte;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                idx_next   = '0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_ERR;
                            end
                        end
                        default:
                        begin
                            state_next = ST_ERR;
                        end
                    endcase
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    status_next = srox_pkg::STATUS_BAD_ARG;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    read_level_next = rd_data[bit_reg];
                    state_next      = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                // Write the modified byte back and start the image read at
                // slot 0; the store bypasses the write if slot 0 is the one.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot_reg;
                mem_req.wr_data = level_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    frame_valid_next = 1'b1;
                    frame_byte_next  = rd_data;
                    last_next        = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg + srox_pkg::SLOT_W'(1);
                        idx_next        = idx_reg + srox_pkg::SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        bit_reg   <= bit_next;
        level_reg <= level_next;
        if (out_load)
        begin
            status_reg      <= status_next;
            read_level_reg  <= read_level_next;
            frame_valid_reg <= frame_valid_next;
            frame_byte_reg  <= frame_byte_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_level  = read_level_reg;
    assign frame_valid = frame_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign last        = last_reg;

    a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == ST_IDLE && in_valid) || state_reg == ST_MOD)
        else $error("image written outside a chip write or a pin update");

    a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_valid_reg |-> !status_reg && !read_level_reg)
        else $error("frame beat carries a status or a read level");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !frame_valid_reg |-> last_reg && frame_byte_reg == '0)
        else $error("read or error beat is not a lone last beat");

endmodule

`default_nettype wire

### src/shift_register_output_expander_unit.sv
// ----------------------------------------------------------------------------
// shift_register_output_expander_unit
// Output expander image for a daisy-chained serial-in/parallel-out chain.
//
// Requests arrive on in_valid/in_stall and results leave on out_valid/
// out_stall; a beat moves when valid is high and stall is low. chip_count is
// written through cfg_we/cfg_wdata; the user must write it only while the
// unit is idle, as the unit itself has no check for this.
// A pin read, or any request with a bad pin, chip or type, gives one beat
// from the read or error state. A pin set reads the byte, writes it back
// modified and then gives one frame beat per chip in use, one per cycle while
// out_stall is low; a chip write writes its byte and then gives the frames the
// same way. The final frame beat carries last, which marks the latch pulse.
// One request is in work at a time. The image store's single read port
// paces the frame stream at one byte a cycle while out_stall is low.
// A result waits in the output register while out_stall is high and the
// sequencer holds until it is taken. Reset clears the image to zero at once
// and sets chip_count to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_output_expander_unit #(
    parameter int MAX_CHIPS = srox_pkg::MAX_CHIPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [srox_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [srox_pkg::REQ_W-1:0]     req_type,
    input  wire logic [srox_pkg::PIN_W-1:0]     pin_number,
    input  wire logic                           pin_level,
    input  wire logic [srox_pkg::BYTE_W-1:0]    chip_number,
    input  wire logic [srox_pkg::BYTE_W-1:0]    chip_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                status,
    output logic                                read_level,
    output logic                                frame_valid,
    output logic [srox_pkg::BYTE_W-1:0]         frame_byte,
    output logic                                last
);

    logic [srox_pkg::CNT_W-1:0]   chip_count_reg;
    logic [srox_pkg::CNT_W-1:0]   n_chips;
    srox_pkg::mem_req_t           mem_req;
    logic [srox_pkg::BYTE_W-1:0]  rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_count_reg <= srox_pkg::CNT_W'(1);
        end
        else if (cfg_we)
        begin
            chip_count_reg <= cfg_wdata;
        end
    end

    // A count beyond the store acts as the store's depth.
    assign n_chips = ({1'b0, chip_count_reg} > (srox_pkg::CNT_W + 1)'(MAX_CHIPS)) ?
                     srox_pkg::CNT_W'(MAX_CHIPS) : chip_count_reg;

    srox_image_mem #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    srox_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_chips     (n_chips),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pin_number  (pin_number),
        .pin_level   (pin_level),
        .chip_number (chip_number),
        .chip_byte   (chip_byte),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_level  (read_level),
        .frame_valid (frame_valid),
        .frame_byte  (frame_byte),
        .last        (last)
    );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shift register output expander. Requests are
// sent through the valid/stall handshake while a scoreboard keeps its own copy
// of the chip image and the chip count, so it predicts every result beat.
// Each beat that leaves the unit is compared field by field with the oldest
// prediction, under several idling patterns and chip count settings.
// ----------------------------------------------------------------------------

module tb;

    localparam int CHIP_SLOTS = srox_pkg::MAX_CHIPS_DEF;
    localparam logic [srox_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [srox_pkg::REQ_W-1:0]  kind;
        logic [srox_pkg::PIN_W-1:0]  pin;
        logic                        level;
        logic [srox_pkg::BYTE_W-1:0] chip;
        logic [srox_pkg::BYTE_W-1:0] data;
    } request_t;

    typedef struct {
        logic                        status;
        logic                        read_level;
        logic                        frame_valid;
        logic [srox_pkg::BYTE_W-1:0] frame_byte;
        logic                        last;
    } beat_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [srox_pkg::CNT_W-1:0]  cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic [srox_pkg::REQ_W-1:0]  req_type;
    logic [srox_pkg::PIN_W-1:0]  pin_number;
    logic                        pin_level;
    logic [srox_pkg::BYTE_W-1:0] chip_number;
    logic [srox_pkg::BYTE_W-1:0] chip_byte;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        status;
    logic                        read_level;
    logic                        frame_valid;
    logic [srox_pkg::BYTE_W-1:0] frame_byte;
    logic                        last;

    // Scoreboard copy of the unit's state.
    logic [srox_pkg::BYTE_W-1:0] image_copy [CHIP_SLOTS];
    logic [srox_pkg::CNT_W-1:0]  count_copy;
    beat_t                       expected_beats [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int items_sent     = 0;
    int beats_checked  = 0;
    int counts_written = 0;

    shift_register_output_expander_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pin_number  (pin_number),
        .pin_level   (pin_level),
        .chip_number (chip_number),
        .chip_byte   (chip_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_level  (read_level),
        .frame_valid (frame_valid),
        .frame_byte  (frame_byte),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int unsigned chips_active();
        return (count_copy > CHIP_SLOTS) ? CHIP_SLOTS : count_copy;
    endfunction

    function automatic void push_image_frames(input int unsigned n);
        beat_t b;
        for (int unsigned i = 0; i < n; i++)
        begin
            b = '{srox_pkg::STATUS_OK, 1'b0, 1'b1, image_copy[i], (i + 1 == n)};
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void apply_request(input request_t rq);
        int unsigned n;
        int unsigned npins;
        int unsigned slot;
        int unsigned bitpos;
        beat_t       b;
        n     = chips_active();
        npins = n * 8;
        b     = '{srox_pkg::STATUS_BAD_ARG, 1'b0, 1'b0, 8'h00, 1'b1};
        case (rq.kind)
            srox_pkg::REQ_PIN_SET, srox_pkg::REQ_PIN_RD:
            begin
                if (rq.pin >= npins)
                begin
                    expected_beats.push_back(b);
                    return;
                end
                // Pin numbering runs from the far end of the chain.
                slot   = (npins - 1 - rq.pin) / 8;
                bitpos = rq.pin % 8;
                if (rq.kind == srox_pkg::REQ_PIN_RD)
                begin
                    b.status     = srox_pkg::STATUS_OK;
                    b.read_level = image_copy[slot][bitpos];
                    expected_beats.push_back(b);
                    return;
                end
                image_copy[slot][bitpos] = rq.level;
                push_image_frames(n);
            end
            srox_pkg::REQ_CHIP_WR:
            begin
                if (rq.chip >= n)
                begin
                    expected_beats.push_back(b);
                    return;
                end
                image_copy[n - 1 - rq.chip] = rq.data;
                push_image_frames(n);
            end
            default:
                expected_beats.push_back(b);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual frame_byte %0h last %0b",
                         $time, frame_byte, last);
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("status", 8'(want.status), 8'(status));
                check_field("read_level", 8'(want.read_level), 8'(read_level));
                check_field("frame_valid", 8'(want.frame_valid), 8'(frame_valid));
                check_field("frame_byte", want.frame_byte, frame_byte);
                check_field("last", 8'(want.last), 8'(last));
                beats_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic request_t mk(input logic [srox_pkg::REQ_W-1:0] kind, input int pin,
                                    input logic level, input int chip, input int data);
        request_t rq;
        rq.kind  = kind;
        rq.pin   = srox_pkg::PIN_W'(pin);
        rq.level = level;
        rq.chip  = srox_pkg::BYTE_W'(chip);
        rq.data  = srox_pkg::BYTE_W'(data);
        return rq;
    endfunction

    task automatic send_req(input request_t rq);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        req_type    <= rq.kind;
        pin_number  <= rq.pin;
        pin_level   <= rq.level;
        chip_number <= rq.chip;
        chip_byte   <= rq.data;
        do @(posedge clk); while (in_stall);
        apply_request(rq);
        items_sent++;
    endtask

    // Waits until every predicted beat has left, plus a short settling pause.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= srox_pkg::CNT_W'(value);
        @(posedge clk);
        cfg_we     <= 1'b0;
        count_copy = srox_pkg::CNT_W'(value);
        counts_written++;
    endtask

    function automatic request_t random_request();
        request_t    rq;
        int unsigned n;
        int unsigned sel;
        n        = chips_active();
        sel      = $urandom_range(99);
        rq.kind  = srox_pkg::REQ_PIN_SET;
        rq.pin   = srox_pkg::PIN_W'($urandom);
        rq.level = 1'($urandom);
        rq.chip  = srox_pkg::BYTE_W'($urandom);
        rq.data  = srox_pkg::BYTE_W'($urandom);
        if (sel < 38)
            rq.kind = srox_pkg::REQ_PIN_SET;
        else if (sel < 70)
            rq.kind = srox_pkg::REQ_CHIP_WR;
        else if (sel < 95)
            rq.kind = srox_pkg::REQ_PIN_RD;
        else
            rq.kind = REQ_UNKNOWN;
        // Most requests address something that exists; the rest are noise.
        if (n > 0 && $urandom_range(9) != 0)
        begin
            rq.pin  = srox_pkg::PIN_W'($urandom_range(n * 8 - 1));
            rq.chip = srox_pkg::BYTE_W'($urandom_range(n - 1));
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_req(mk(srox_pkg::REQ_PIN_RD, 0, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_RD, 7, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_RD, 8, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 0, 8'hFF));
        send_req(mk(srox_pkg::REQ_PIN_RD, 7, 1'b0, 0, 0));
    endtask

    task automatic test_full_chain();
        write_count(32);
        send_req(mk(srox_pkg::REQ_PIN_SET, 0, 1'b1, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_SET, 255, 1'b1, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_SET, 256, 1'b1, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_RD, 511, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 31, 8'h00));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 0, 8'hA5));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 32, 8'hFF));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 255, 8'hFF));
        send_req(mk(srox_pkg::REQ_PIN_SET, 255, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_PIN_RD, 0, 1'b0, 0, 0));
        send_req(mk(REQ_UNKNOWN, 0, 1'b1, 0, 8'hFF));
    endtask

    // With no chips in use nothing is addressable.
    task automatic test_zero_count();
        write_count(0);
        send_req(mk(srox_pkg::REQ_PIN_SET, 0, 1'b1, 0, 0));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 0, 8'h3C));
        send_req(mk(srox_pkg::REQ_PIN_RD, 0, 1'b0, 0, 0));
    endtask

    // A count beyond the store size behaves as a full store.
    task automatic test_count_clamp();
        write_count(63);
        send_req(mk(srox_pkg::REQ_PIN_RD, 255, 1'b0, 0, 0));
        send_req(mk(srox_pkg::REQ_CHIP_WR, 0, 1'b0, 31, 8'h5A));
        send_req(mk(srox_pkg::REQ_PIN_SET, 256, 1'b1, 0, 0));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct, input int items);
        write_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (items)
            send_req(random_request());
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        req_type    <= '0;
        pin_number  <= '0;
        pin_level   <= 1'b0;
        chip_number <= '0;
        chip_byte   <= '0;
        foreach (image_copy[i])
            image_copy[i] = '0;
        count_copy = srox_pkg::CNT_W'(1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_full_chain();
        test_zero_count();
        test_count_clamp();
        test_random_traffic(32, 0, 0, 80);
        test_random_traffic(5, 74, 0, 80);
        test_random_traffic(1, 0, 74, 80);
        test_random_traffic($urandom_range(2, 63), 38, 38, 90);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();

        if (expected_beats.size() != 0)
            errors++;
        $display("Sent %0d requests across %0d chip count settings, checked %0d result beats.",
                 items_sent, counts_written, beats_checked);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
src/srox_pkg.sv
src/srox_image_mem.sv
src/srox_seq.sv
src/shift_register_output_expander_unit.sv
verif/tb.sv
